@@ rtl/core/plct_pkg.sv @@
`default_nettype none
package plct_pkg;
   localparam logic [1:0] ACT_SET    = 2'd0;
   localparam logic [1:0] ACT_INTERP = 2'd1;
   localparam logic [1:0] ACT_SLOPE  = 2'd2;
   localparam logic [1:0] ACT_CLEAR  = 2'd3;

   localparam logic [1:0] REG_INSIDE = 2'd0;
   localparam logic [1:0] REG_LEFT   = 2'd1;
   localparam logic [1:0] REG_RIGHT  = 2'd2;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_SAT  = 2'd2;

   localparam logic CSR_OOB_LEFT  = 1'b0;
   localparam logic CSR_OOB_RIGHT = 1'b1;

   typedef struct packed {
      logic [31:0] key;
      logic [31:0] val;
   } point_type;
endpackage
`default_nettype wire

@@ rtl/core/piecewise_linear_curve_table.sv @@
// Channel | Direction | Handshake           | Payload
// req     | in        | req_valid/req_stall | req_action, req_x_coord, req_y_value
// rsp     | out       | rsp_valid/rsp_stall | rsp_result_value, rsp_region, rsp_status,
//         |           |                     | rsp_point_total
// csr     | in        | csr_write_en        | csr_index, csr_data
//
// One transaction at a time. A search walks the point memory one entry a
// cycle. A set that inserts then shifts the tail up one entry at a time,
// reading each entry and then writing it one place higher. Interpolate adds
// a multiply step, and interpolate and slope run a restoring divider with a
// 64-bit quotient. Reset is synchronous; the point memory is not cleared,
// but the count and the out-of-range values are. A stalled response holds
// in the output register and blocks new requests only once the next one
// has finished.
`default_nettype none
module piecewise_linear_curve_table
   import plct_pkg::*;
#(
   parameter int MAX_POINTS = 64,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_action,
   input  wire logic signed [31:0] req_x_coord,
   input  wire logic signed [31:0] req_y_value,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [31:0]      rsp_result_value,
   output logic [1:0]              rsp_region,
   output logic [1:0]              rsp_status,
   output logic [6:0]              rsp_point_total,
   input  wire logic               csr_write_en,
   input  wire logic               csr_index,
   input  wire logic [31:0]        csr_data
);
   localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CW = $clog2(MAX_POINTS + 1);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_SRCH  = 4'd1;  // read issued for idx
   localparam logic [3:0] S_SHRD  = 4'd2;  // read k-1 issued
   localparam logic [3:0] S_SHWR  = 4'd3;  // write k
   localparam logic [3:0] S_RDN   = 4'd4;  // read i+1 issued
   localparam logic [3:0] S_CALC  = 4'd5;
   localparam logic [3:0] S_MUL   = 4'd6;
   localparam logic [3:0] S_DIV   = 4'd7;
   localparam logic [3:0] S_FIN   = 4'd8;
   localparam logic [3:0] S_OUT   = 4'd9;

   point_type mem [MAX_POINTS];
   point_type rd_q;
   logic [AW-1:0] rd_addr, wr_addr;
   logic rd_en, wr_en;
   point_type wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_q <= mem[rd_addr];
   end

   logic [3:0] state_ff, state_in;
   logic [CW-1:0] count_ff, count_in, idx_ff, idx_in;
   logic signed [31:0] left_ff, right_ff;
   logic [1:0] act_ff, act_in;
   logic signed [31:0] x_ff, x_in, y_ff, y_in;
   point_type prev_ff, prev_in, cur_ff, cur_in, hold_ff, hold_in;
   logic [63:0] num_ff, num_in;
   logic [63:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [32:0] den_ff, den_in;
   logic neg_ff, neg_in, slope_ff, slope_in;
   logic [6:0] dcnt_ff, dcnt_in;
   logic signed [31:0] res_ff, res_in;
   logic [1:0] reg_ff, reg_in, st_ff, st_in;
   logic vld_ff, vld_in;
   // response register: holds the payload while the receiver stalls
   logic signed [31:0] out_res_ff, out_res_in;
   logic [1:0] out_reg_ff, out_reg_in, out_st_ff, out_st_in;
   logic [6:0] out_total_ff, out_total_in;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = vld_ff;
   assign rsp_result_value = out_res_ff;
   assign rsp_region = out_reg_ff;
   assign rsp_status = out_st_ff;
   assign rsp_point_total = out_total_ff;

   logic signed [32:0] dy_s, dx_s, span_s;
   logic [32:0] dy_mag;
   logic [64:0] rem_try;
   logic [63:0] lim;

   always_comb begin
      state_in = state_ff; count_in = count_ff; idx_in = idx_ff;
      act_in = act_ff; x_in = x_ff; y_in = y_ff;
      prev_in = prev_ff; cur_in = cur_ff; hold_in = hold_ff;
      num_in = num_ff; rem_in = rem_ff; quo_in = quo_ff; den_in = den_ff;
      neg_in = neg_ff; slope_in = slope_ff; dcnt_in = dcnt_ff;
      res_in = res_ff; reg_in = reg_ff; st_in = st_ff; vld_in = vld_ff;
      out_res_in = out_res_ff; out_reg_in = out_reg_ff; out_st_in = out_st_ff;
      out_total_in = out_total_ff;
      rd_en = 1'b0; rd_addr = AW'(idx_ff); wr_en = 1'b0;
      wr_addr = AW'(idx_ff); wr_data = cur_ff;
      dy_s = '0; dx_s = '0; span_s = '0; dy_mag = '0; rem_try = '0; lim = '0;
      if (vld_ff && !rsp_stall) vld_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               act_in = req_action; x_in = req_x_coord; y_in = req_y_value;
               idx_in = '0; res_in = '0; reg_in = REG_INSIDE; st_in = ST_OK;
               if (req_action == ACT_CLEAR) begin
                  count_in = '0; state_in = S_OUT;
               end else if (count_ff == '0) begin
                  state_in = S_CALC;
               end else begin
                  rd_en = 1'b1; rd_addr = '0; state_in = S_SRCH;
               end
            end
         end
         S_SRCH: begin
            // rd_q holds entry idx
            if ($signed(rd_q.key) < x_ff) begin
               prev_in = rd_q;
               idx_in = idx_ff + 1'b1;
               if (idx_ff + 1'b1 == count_ff) state_in = S_CALC;
               else begin
                  rd_en = 1'b1; rd_addr = AW'(idx_ff + 1'b1);
               end
            end else begin
               cur_in = rd_q;
               if (act_ff == ACT_SLOPE && idx_ff != '0 && $signed(rd_q.key) == x_ff
                   && idx_ff + 1'b1 < count_ff) begin
                  rd_en = 1'b1; rd_addr = AW'(idx_ff + 1'b1); state_in = S_RDN;
               end else state_in = S_CALC;
            end
         end
         S_RDN: begin
            cur_in = rd_q; state_in = S_CALC;
            slope_in = 1'b1;
         end
         S_CALC: begin
            if (act_ff == ACT_SET) begin
               if (idx_ff < count_ff && $signed(cur_ff.key) == x_ff) begin
                  wr_en = 1'b1; wr_addr = AW'(idx_ff);
                  wr_data.key = cur_ff.key; wr_data.val = y_ff;
                  state_in = S_OUT;
               end else if (count_ff >= CW'(MAX_POINTS)) begin
                  st_in = ST_FULL; state_in = S_OUT;
               end else begin
                  // shift tail up from the top: k = count
                  dcnt_in = 7'd0;
                  hold_in.key = x_ff; hold_in.val = y_ff;
                  idx_in = count_ff;
                  num_in = 64'(idx_ff);  // insert position
                  if (count_ff == idx_ff) begin
                     wr_en = 1'b1; wr_addr = AW'(idx_ff);
                     wr_data.key = x_ff; wr_data.val = y_ff;
                     count_in = count_ff + 1'b1; state_in = S_OUT;
                  end else begin
                     rd_en = 1'b1; rd_addr = AW'(count_ff - 1'b1);
                     state_in = S_SHRD;
                  end
               end
            end else if (idx_ff >= count_ff) begin
               reg_in = REG_RIGHT;
               res_in = (act_ff == ACT_INTERP) ? right_ff : '0;
               state_in = S_OUT;
            end else if (idx_ff == '0) begin
               if (x_ff < $signed(cur_ff.key)) begin
                  reg_in = REG_LEFT;
                  res_in = (act_ff == ACT_INTERP) ? left_ff : '0;
               end else res_in = (act_ff == ACT_INTERP) ? $signed(cur_ff.val) : '0;
               state_in = S_OUT;
            end else if (act_ff == ACT_SLOPE && $signed(cur_ff.key) == x_ff
                         && !slope_ff) begin
               res_in = '0; state_in = S_OUT;
            end else begin
               dy_s = 33'(signed'(cur_ff.val)) - 33'(signed'(prev_ff.val));
               span_s = 33'(signed'(cur_ff.key)) - 33'(signed'(prev_ff.key));
               dx_s = 33'(x_ff) - 33'(signed'(prev_ff.key));
               neg_in = dy_s[32];
               dy_mag = dy_s[32] ? 33'(-dy_s) : 33'(dy_s);
               den_in = span_s;
               rem_in = '0; quo_in = '0; dcnt_in = 7'd64;
               if (act_ff == ACT_INTERP) begin
                  num_in = {31'd0, dy_mag};
                  hold_in.key = 32'(dx_s);  // dx fits 32 bits unsigned
                  state_in = S_MUL;
               end else begin
                  num_in = 64'(dy_mag) << FRAC_BITS;
                  state_in = S_DIV;
               end
            end
         end
         S_SHRD: begin
            state_in = S_SHWR;
         end
         S_SHWR: begin
            wr_en = 1'b1; wr_addr = AW'(idx_ff); wr_data = rd_q;
            idx_in = idx_ff - 1'b1;
            if (idx_ff - 1'b1 == CW'(num_ff)) begin
               state_in = S_FIN;
            end else begin
               rd_en = 1'b1; rd_addr = AW'(idx_ff - 2'd2); state_in = S_SHRD;
            end
         end
         S_FIN: begin
            if (act_ff == ACT_SET) begin
               wr_en = 1'b1; wr_addr = AW'(idx_ff); wr_data = hold_ff;
               count_in = count_ff + 1'b1; state_in = S_OUT;
            end else begin
               if (act_ff == ACT_INTERP) begin
                  res_in = neg_ff ? 32'(signed'(prev_ff.val) - signed'(quo_ff[32:0]))
                                  : 32'(signed'(prev_ff.val) + signed'(quo_ff[32:0]));
               end else begin
                  lim = neg_ff ? 64'h8000_0000 : 64'h7FFF_FFFF;
                  if (quo_ff > lim) begin
                     st_in = ST_SAT;
                     res_in = neg_ff ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                  end else res_in = neg_ff ? 32'(-quo_ff[31:0]) : quo_ff[31:0];
               end
               state_in = S_OUT;
            end
         end
         S_MUL: begin
            num_in = 64'(num_ff[32:0]) * 64'(hold_ff.key);
            state_in = S_DIV;
         end
         S_DIV: begin
            rem_try = {rem_ff, num_ff[63]} - {32'd0, den_ff};
            num_in = num_ff << 1;
            if (!rem_try[64]) begin
               rem_in = rem_try[63:0]; quo_in = {quo_ff[62:0], 1'b1};
            end else begin
               rem_in = {rem_ff[62:0], num_ff[63]}; quo_in = {quo_ff[62:0], 1'b0};
            end
            dcnt_in = dcnt_ff - 1'b1;
            if (dcnt_ff == 7'd1) state_in = S_FIN;
         end
         S_OUT: begin
            // hand off only once the previous response has left
            if (!vld_ff || !rsp_stall) begin
               vld_in = 1'b1; slope_in = 1'b0; state_in = S_IDLE;
               out_res_in = res_ff; out_reg_in = reg_ff; out_st_in = st_ff;
               out_total_in = 7'(count_ff);
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (state_ff == S_OUT && (!vld_ff || !rsp_stall)) vld_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; count_ff <= '0; vld_ff <= 1'b0;
         left_ff <= '0; right_ff <= '0; slope_ff <= 1'b0;
      end else begin
         state_ff <= state_in; count_ff <= count_in; vld_ff <= vld_in;
         slope_ff <= slope_in;
         if (csr_write_en && csr_index == CSR_OOB_LEFT) left_ff <= csr_data;
         if (csr_write_en && csr_index == CSR_OOB_RIGHT) right_ff <= csr_data;
      end
      idx_ff <= idx_in; act_ff <= act_in; x_ff <= x_in; y_ff <= y_in;
      prev_ff <= prev_in; cur_ff <= cur_in; hold_ff <= hold_in;
      num_ff <= num_in; rem_ff <= rem_in; quo_ff <= quo_in; den_ff <= den_in;
      neg_ff <= neg_in; dcnt_ff <= dcnt_in;
      res_ff <= res_in; reg_ff <= reg_in; st_ff <= st_in;
      out_res_ff <= out_res_in; out_reg_ff <= out_reg_in; out_st_ff <= out_st_in;
      out_total_ff <= out_total_in;
   end

`ifndef SYNTH
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_POINTS)) else $error("point count overflow");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_value))
      else $error("response dropped");
   a_region_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_region != REG_INSIDE |-> rsp_status != ST_FULL)
      else $error("bad region/status");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> req_stall) else $error("accept during divide");
`endif
endmodule
`default_nettype wire
